/* src/sha_pkg.sv */
// Package with SHA-256 constants, types and round functions.
`default_nettype none
package sha_pkg;
   localparam int unsigned WordWidth = 32;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_LOAD,
      ST_ROUND,
      ST_FOLD,
      ST_EMIT
   } state_type;

   localparam logic REQ_ABSORB = 1'b0;
   localparam logic REQ_FINISH = 1'b1;

   function automatic logic [31:0] round_k(input logic [5:0] t);
      logic [31:0] k [64];
      k = '{
         32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
         32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
         32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
         32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
         32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
         32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
         32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
         32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
         32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
         32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
         32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
         32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
         32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
         32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
         32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
         32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
      return k[t];
   endfunction

   function automatic logic [31:0] init_hash(input logic [2:0] i);
      logic [31:0] h [8];
      h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
            32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
      return h[i];
   endfunction

   function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction
endpackage
`default_nettype wire

/* src/sha256_stream_hasher.sv */
// Streaming SHA-256 hasher top level.
// Usage:
//   req_ channel: tdata[7:0] = data_byte, tuser = operation (0 absorb, 1 finish).
//   rsp_ channel: tdata[31:0] = digest_word, tdata[34:32] = word_index,
//   tdata[39:35] zero, tlast on the eighth word.
//   Absorb requests are taken while idle with no wait state, so they can follow back to back.
//   The 64th byte of a block starts a compression that holds off requests:
//   the load state reads 16 words from the byte buffer memory (one byte read
//   per cycle through its registered read port), then 64 rounds run at one per
//   cycle, then the fold state adds the result into the chaining value.
//   A finish request writes 0x80, then pads one byte per cycle up to the end
//   of the block, runs the compression, and when the length does not fit
//   pads a second block and runs a second compression. The first digest word
//   is valid once the last compression has been folded; the eight words then
//   follow at one per cycle while rsp_tready is high.
//   Reset returns the chaining value to the initial hash and clears counts.
//   A stalled receiver holds the current digest word; no request is taken
//   until all eight words are delivered.
`default_nettype none
module sha256_stream_hasher (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,  // data_byte[7:0]
   input  wire logic        req_tuser,  // operation
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,  // digest_word[31:0], word_index[34:32], zero
   output logic             rsp_tlast
);
   sha_pkg::state_type state_ff, state_in;
   logic [5:0]  fill_ff, fill_in;
   logic [31:0] count_ff, count_in;
   logic [7:0]  step_ff, step_in;     // load byte / round / emit counter
   logic        fin_ff, fin_in;       // finishing message
   logic        pad_len_ff, pad_len_in; // length bytes go into the block being padded
   logic [31:0] cv_ff [8];
   logic [31:0] cv_in [8];
   logic [31:0] r_ff [8];
   logic [31:0] r_in [8];
   logic [31:0] wacc_ff, wacc_in;
   logic [31:0] w_ff [16];
   logic [31:0] w_in [16];

   logic       buf_we;
   logic [5:0] buf_wa, buf_ra;
   logic [7:0] buf_wd, buf_rd;

   sha_ram #(.Width(8), .Depth(64)) u_buf (
      .clock(clock), .wr_en(buf_we), .wr_addr(buf_wa), .wr_data(buf_wd),
      .rd_addr(buf_ra), .rd_data(buf_rd));

   logic        acc;
   logic [63:0] bitlen;
   logic [31:0] wt, t1, t2, s0, s1;
   logic [5:0]  rnd;

   assign acc    = req_tvalid && req_tready;
   assign bitlen = {29'd0, count_ff, 3'd0};
   assign rnd    = step_ff[5:0];

   always_comb begin
      s1 = sha_pkg::rotr(w_ff[14], 17) ^ sha_pkg::rotr(w_ff[14], 19) ^ (w_ff[14] >> 10);
      s0 = sha_pkg::rotr(w_ff[1], 7) ^ sha_pkg::rotr(w_ff[1], 18) ^ (w_ff[1] >> 3);
      wt = w_ff[0];
      t1 = r_ff[7] + (sha_pkg::rotr(r_ff[4], 6) ^ sha_pkg::rotr(r_ff[4], 11) ^
           sha_pkg::rotr(r_ff[4], 25)) + ((r_ff[4] & r_ff[5]) ^ (~r_ff[4] & r_ff[6])) +
           sha_pkg::round_k(rnd) + wt;
      t2 = (sha_pkg::rotr(r_ff[0], 2) ^ sha_pkg::rotr(r_ff[0], 13) ^
           sha_pkg::rotr(r_ff[0], 22)) +
           ((r_ff[0] & r_ff[1]) ^ (r_ff[0] & r_ff[2]) ^ (r_ff[1] & r_ff[2]));
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sha_pkg::ST_IDLE: begin
            if (acc && fill_ff == 6'd63) begin
               state_in = sha_pkg::ST_LOAD;
            end else if (acc && req_tuser == sha_pkg::REQ_FINISH) begin
               state_in = sha_pkg::ST_PAD;
            end
         end
         sha_pkg::ST_PAD: begin
            if (fill_ff == 6'd63) begin
               state_in = sha_pkg::ST_LOAD;
            end
         end
         sha_pkg::ST_LOAD: begin
            if (step_ff == 8'd64) begin
               state_in = sha_pkg::ST_ROUND;
            end
         end
         sha_pkg::ST_ROUND: begin
            if (step_ff == 8'd63) begin
               state_in = sha_pkg::ST_FOLD;
            end
         end
         sha_pkg::ST_FOLD: begin
            if (!fin_ff) begin
               state_in = sha_pkg::ST_IDLE;
            end else if (pad_len_ff) begin
               state_in = sha_pkg::ST_EMIT;
            end else begin
               state_in = sha_pkg::ST_PAD;
            end
         end
         sha_pkg::ST_EMIT: begin
            if (rsp_tready && step_ff[2:0] == 3'd7) begin
               state_in = sha_pkg::ST_IDLE;
            end
         end
         default: state_in = sha_pkg::ST_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      fill_in    = fill_ff;
      count_in   = count_ff;
      step_in    = step_ff;
      fin_in     = fin_ff;
      pad_len_in = pad_len_ff;
      cv_in      = cv_ff;
      r_in       = r_ff;
      w_in       = w_ff;
      wacc_in    = wacc_ff;
      buf_we     = 1'b0;
      buf_wa     = fill_ff;
      buf_wd     = req_tdata;
      buf_ra     = step_ff[5:0];
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      unique case (state_ff)
         sha_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            step_in    = 8'd0;
            if (acc && req_tuser == sha_pkg::REQ_ABSORB) begin
               buf_we   = 1'b1;
               fill_in  = fill_ff + 6'd1;
               count_in = count_ff + 32'd1;
            end else if (acc) begin
               buf_we     = 1'b1;
               buf_wd     = 8'h80;
               fin_in     = 1'b1;
               pad_len_in = (fill_ff < 6'd56);
               fill_in    = fill_ff + 6'd1;
            end
         end
         sha_pkg::ST_PAD: begin
            buf_we  = 1'b1;
            step_in = 8'd0;
            if (pad_len_ff && fill_ff >= 6'd56) begin
               buf_wd = bitlen[8'(63 - 8 * (fill_ff - 6'd56)) -: 8];
            end else begin
               buf_wd = 8'h00;
            end
            fill_in = fill_ff + 6'd1;
         end
         sha_pkg::ST_LOAD: begin
            // byte i read at step i, lands at step i+1
            step_in = step_ff + 8'd1;
            if (step_ff != 8'd0) begin
               wacc_in = {wacc_ff[23:0], buf_rd};
               if (step_ff[1:0] == 2'd0) begin
                  w_in[15] = {wacc_ff[23:0], buf_rd};
                  for (int j = 0; j < 15; j++) begin
                     w_in[j] = w_ff[j + 1];
                  end
               end
            end
            if (step_ff == 8'd64) begin
               r_in    = cv_ff;
               step_in = 8'd0;
            end
         end
         sha_pkg::ST_ROUND: begin
            step_in = step_ff + 8'd1;
            for (int j = 0; j < 15; j++) begin
               w_in[j] = w_ff[j + 1];
            end
            w_in[15] = s1 + w_ff[9] + s0 + w_ff[0];
            r_in[7] = r_ff[6];
            r_in[6] = r_ff[5];
            r_in[5] = r_ff[4];
            r_in[4] = r_ff[3] + t1;
            r_in[3] = r_ff[2];
            r_in[2] = r_ff[1];
            r_in[1] = r_ff[0];
            r_in[0] = t1 + t2;
            if (step_ff == 8'd63) begin
               step_in = 8'd0;
            end
         end
         sha_pkg::ST_FOLD: begin
            for (int j = 0; j < 8; j++) begin
               cv_in[j] = cv_ff[j] + r_ff[j];
            end
            if (fin_ff && !pad_len_ff) begin
               pad_len_in = 1'b1;
            end
         end
         sha_pkg::ST_EMIT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               step_in = step_ff + 8'd1;
               if (step_ff[2:0] == 3'd7) begin
                  for (int j = 0; j < 8; j++) begin
                     cv_in[j] = sha_pkg::init_hash(3'(j));
                  end
                  fill_in  = 6'd0;
                  count_in = 32'd0;
                  fin_in   = 1'b0;
                  step_in  = 8'd0;
               end
            end
         end
         default: ;
      endcase
   end

   assign rsp_tdata = {5'd0, step_ff[2:0], cv_ff[step_ff[2:0]]};
   assign rsp_tlast = (step_ff[2:0] == 3'd7);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= sha_pkg::ST_IDLE;
         fill_ff    <= 6'd0;
         count_ff   <= 32'd0;
         step_ff    <= 8'd0;
         fin_ff     <= 1'b0;
         pad_len_ff <= 1'b0;
         for (int j = 0; j < 8; j++) begin
            cv_ff[j] <= sha_pkg::init_hash(3'(j));
         end
      end else begin
         state_ff   <= state_in;
         fill_ff    <= fill_in;
         count_ff   <= count_in;
         step_ff    <= step_in;
         fin_ff     <= fin_in;
         pad_len_ff <= pad_len_in;
         cv_ff      <= cv_in;
      end
      r_ff    <= r_in;
      w_ff    <= w_in;
      wacc_ff <= wacc_in;
   end
endmodule
`default_nettype wire

/* src/sha_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none
module sha_ram #(
   parameter int unsigned Width = 8,
   parameter int unsigned Depth = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

/* src/sha256_stream_hasher_checker.sv */
// Port-level checker for the SHA-256 stream hasher, with its bind.
`default_nettype none
module sha256_stream_hasher_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [39:0] rsp_tdata,
   input wire logic        rsp_tlast
);
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("request taken during digest");
   a_last_idx: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tdata[34:32] == 3'd7)))
      else $error("tlast mismatch");
   a_idx_step: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid &&
      rsp_tdata[34:32] == $past(rsp_tdata[34:32]) + 3'd1)
      else $error("word index skipped");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled word changed");
endmodule

bind sha256_stream_hasher sha256_stream_hasher_checker u_checker (
   .clock(clock), .reset(reset), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
   .rsp_tlast(rsp_tlast));
`default_nettype wire

/* sim/sha256_stream_hasher_test.sv */
// Testbench for the streaming SHA-256 hasher: predicts each digest and checks every word.
`timescale 1ns / 100ps
`default_nettype none
module sha256_stream_hasher_test;
   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // data_byte[7:0]
   logic        req_tuser;   // operation
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;   // digest_word[31:0], word_index[34:32], zero
   logic        rsp_tlast;

   sha256_stream_hasher u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
   );

   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last;
   } digest_word_type;

   localparam logic [31:0] Ks [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
   localparam logic [31:0] Iv [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   logic [31:0]     hash_state [8];
   logic [7:0]      block_bytes [64];
   logic [5:0]      fill;
   logic [31:0]     msg_length;
   digest_word_type digest_queue [$];
   bit              failed;
   bit              hold_receiver;
   int unsigned     cycle_count;
   int unsigned     rsp_wait;

   function automatic logic [31:0] ror(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   task automatic compress_block();
      logic [31:0] w [64];
      logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
      for (int j = 0; j < 16; j++)
         w[j] = {block_bytes[4*j], block_bytes[4*j+1], block_bytes[4*j+2], block_bytes[4*j+3]};
      for (int t = 16; t < 64; t++)
         w[t] = (ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7]
              + (ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
      {a, b, c, d, e, f, g, h} = {hash_state[0], hash_state[1], hash_state[2], hash_state[3],
                                  hash_state[4], hash_state[5], hash_state[6], hash_state[7]};
      for (int t = 0; t < 64; t++) begin
         t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g)) + Ks[t] + w[t];
         t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
         h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
      end
      hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
      hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
   endtask

   task automatic buffer_byte(input logic [7:0] b);
      block_bytes[fill] = b;
      fill = fill + 6'd1;
      if (fill == 6'd0)
         compress_block();
   endtask

   task automatic predict_request(input logic op, input logic [7:0] b);
      logic [63:0] bit_length;
      if (op == sha_pkg::REQ_ABSORB) begin
         msg_length++;
         buffer_byte(b);
      end else begin
         bit_length = {29'd0, msg_length, 3'd0};
         buffer_byte(8'h80);
         while (fill != 6'd56)
            buffer_byte(8'h00);
         for (int i = 7; i >= 0; i--)
            buffer_byte(bit_length[8*i +: 8]);
         for (int i = 0; i < 8; i++)
            digest_queue.push_back('{hash_state[i], 3'(i), i == 7});
         hash_state = Iv;
         fill = 6'd0;
         msg_length = 0;
      end
   endtask

   task automatic send_request(input logic op, input logic [7:0] b, input bit gaps = 1);
      if (gaps)
         repeat ($urandom_range(0, 10) * $urandom_range(0, 1)) @(negedge clock);
      req_tvalid = 1'b1;
      req_tuser  = op;
      req_tdata  = b;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      predict_request(op, b);
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task automatic wait_for_digests();
      while (digest_queue.size() != 0)
         @(negedge clock);
   endtask

   task automatic test_empty_and_short();
      send_request(sha_pkg::REQ_FINISH, 8'hff);
      send_request(sha_pkg::REQ_ABSORB, 8'h00);
      send_request(sha_pkg::REQ_FINISH, 8'h00);
      send_request(sha_pkg::REQ_ABSORB, 8'h61);
      send_request(sha_pkg::REQ_ABSORB, 8'h62);
      send_request(sha_pkg::REQ_ABSORB, 8'h63);
      send_request(sha_pkg::REQ_FINISH, 8'h5a);
   endtask

   task automatic test_padding_edges();
      int lengths [2] = '{56, 63};
      foreach (lengths[k]) begin
         for (int i = 0; i < lengths[k]; i++)
            send_request(sha_pkg::REQ_ABSORB, 8'($urandom), 0);
         send_request(sha_pkg::REQ_FINISH, 8'($urandom));
      end
      wait_for_digests();
   endtask

   task automatic test_random_messages();
      int sent;
      sent = 0;
      while (sent < 12) begin
         int len;
         len = $urandom_range(0, 8);
         for (int i = 0; i < len; i++)
            send_request(sha_pkg::REQ_ABSORB, 8'($urandom));
         send_request(sha_pkg::REQ_FINISH, 8'($urandom));
         sent += len + 1;
      end
   endtask

   task automatic test_backpressure();
      hold_receiver = 1;
      fork
         begin
            repeat (300) @(negedge clock);
            hold_receiver = 0;
         end
         for (int m = 0; m < 3; m++) begin
            send_request(sha_pkg::REQ_ABSORB, 8'($urandom), 0);
            send_request(sha_pkg::REQ_FINISH, 8'h00, 0);
         end
      join
      wait_for_digests();
   endtask

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("FAIL sha256_stream_hasher");
         $finish;
      end
   end

   always @(negedge clock)
      if (reset || hold_receiver) begin
         rsp_tready <= 1'b0;
      end else if (rsp_wait != 0) begin
         rsp_tready <= 1'b0;
         rsp_wait = rsp_wait - 1;
      end else begin
         rsp_tready <= 1'b1;
      end

   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_wait = $urandom_range(0, 10);
         if (digest_queue.size() == 0) begin
            $display("%0t unexpected digest word: actual %h", $time, rsp_tdata);
            failed = 1;
         end else begin
            digest_word_type exp;
            exp = digest_queue.pop_front();
            if (rsp_tdata[31:0] !== exp.word || rsp_tdata[34:32] !== exp.index ||
                rsp_tdata[39:35] !== 5'd0 || rsp_tlast !== exp.last) begin
               $display("%0t digest mismatch: expected %h idx %0d last %b, actual %h last %b",
                        $time, exp.word, exp.index, exp.last, rsp_tdata, rsp_tlast);
               failed = 1;
            end
         end
      end

   initial begin
      failed = 0;
      hold_receiver = 0;
      cycle_count = 0;
      rsp_wait = 0;
      reset = 1;
      req_tvalid = 0;
      req_tdata = 0;
      req_tuser = 0;
      rsp_tready = 0;
      hash_state = Iv;
      fill = 0;
      msg_length = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 0;
      test_empty_and_short();
      test_padding_edges();
      test_backpressure();
      test_random_messages();
      wait_for_digests();
      repeat (200) @(negedge clock);
      if (!failed && digest_queue.size() == 0)
         $display("PASS sha256_stream_hasher");
      else
         $display("FAIL sha256_stream_hasher");
      $finish;
   end
endmodule
`default_nettype wire
